/* hdl/qti_pkg.sv */
// Shared types and constants of the quadrilinear table interpolator.
// Used by the divider and the top level; no dependencies.
package qti_pkg;

  // default table geometry
  localparam int ENERGY_BINS_DEF        = 8;
  localparam int FIRST_AXIS_POINTS_DEF  = 16;
  localparam int SECOND_AXIS_POINTS_DEF = 16;
  localparam int POLAR_POINTS_DEF       = 8;
  localparam int AZIMUTH_POINTS_DEF     = 8;

  // datapath widths
  localparam int WORD_W = 32;
  localparam int TERM_WORDS = 5;               // value times four distances
  localparam int TERM_W = TERM_WORDS * WORD_W;  // 160
  localparam int ACC_W = TERM_W + 4;            // sum of 16 terms
  localparam int DVS_W = 4 * WORD_W;            // product of four spacings

  // request kinds
  typedef enum logic [2:0] {
    REQ_LOAD_VAL   = 3'd0,
    REQ_LOAD_S12   = 3'd1,
    REQ_LOAD_S23   = 3'd2,
    REQ_LOAD_THETA = 3'd3,
    REQ_LOAD_ALPHA = 3'd4,
    REQ_BRACKET    = 3'd5,
    REQ_QUERY      = 3'd6
  } req_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GRD,
    ST_SPC,
    ST_CHK,
    ST_DMUL,
    ST_DSTO,
    ST_CADR,
    ST_CRD,
    ST_CCAP,
    ST_CMUL,
    ST_CADD,
    ST_DIVS,
    ST_DIVW,
    ST_FIN
  } state_t;

endpackage

/* hdl/qti_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module qti_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/qti_div.sv */
// Bit-serial restoring divider with saturation to a 32-bit quotient.
// Depends on qti_pkg for widths.
module qti_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [qti_pkg::ACC_W-1:0]  dividend,
  input  logic [qti_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [qti_pkg::WORD_W-1:0] quotient
);

  localparam int RW = qti_pkg::DVS_W + qti_pkg::WORD_W;  // 160

  logic                       busy_r;
  logic                       done_r;
  logic [4:0]                 cnt_r;
  logic [RW-1:0]              rem_r;
  logic [RW-1:0]              dsh_r;
  logic [qti_pkg::WORD_W-1:0] q_r;
  logic                       ovf;
  logic                       ge;

  // quotient would not fit in 32 bits
  assign ovf = dividend >= qti_pkg::ACC_W'({divisor, {qti_pkg::WORD_W{1'b0}}});
  assign ge  = rem_r >= dsh_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= !ovf;
        done_r <= ovf;
      end else if (busy_r && cnt_r == 5'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[RW-1:0];
      dsh_r <= {1'b0, divisor, {(qti_pkg::WORD_W-1){1'b0}}};
      cnt_r <= 5'd31;
      q_r   <= ovf ? {qti_pkg::WORD_W{1'b1}} : '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r    <= rem_r - dsh_r;
        q_r[cnt_r] <= 1'b1;
      end
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

/* hdl/quadrilinear_table_interpolator_top.sv */
// Top level of the quadrilinear table interpolator: sequencer, word-serial
// multiplier, value and grid memories. Depends on qti_pkg, qti_ram, qti_div.
//
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | in_tdata (bins, coordinates), in_tuser (kind)
// out_    | out | out_tvalid/out_tready| out_tdata (value), out_tuser (flag)
//
// Loads and bracket requests are handled as they are accepted. A query runs
// eight grid reads, the divisor product, for each corner the table read and
// the word-serial 32x32 multiply chain, and then the bit-serial divider. A
// degenerate query finishes without the multiplies and the divider.
// Reset clears control state and the held lower bins; memories are not
// cleared. A stalled result holds in the output register; loads are still
// taken meanwhile, a second query waits for the slot before finishing.
module quadrilinear_table_interpolator_top #(
  parameter int ENERGY_BINS        = qti_pkg::ENERGY_BINS_DEF,
  parameter int FIRST_AXIS_POINTS  = qti_pkg::FIRST_AXIS_POINTS_DEF,
  parameter int SECOND_AXIS_POINTS = qti_pkg::SECOND_AXIS_POINTS_DEF,
  parameter int POLAR_POINTS       = qti_pkg::POLAR_POINTS_DEF,
  parameter int AZIMUTH_POINTS     = qti_pkg::AZIMUTH_POINTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // energy_bin, s12_bin, s23_bin, theta_bin, alpha_bin,
  // s12_value, s23_value, theta_value, alpha_value, zero pad
  input  logic [151:0] in_tdata,
  input  logic [2:0]   in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // interpolated_value
  output logic [0:0]   out_tuser   // degenerate_flag
);

  localparam int E = ENERGY_BINS;
  localparam int F = FIRST_AXIS_POINTS;
  localparam int S = SECOND_AXIS_POINTS;
  localparam int P = POLAR_POINTS;
  localparam int A = AZIMUTH_POINTS;
  localparam int TSZ = E * S * F * P * A;
  localparam int TAW = $clog2(TSZ);
  localparam int GD  = F * E + S * E + P + A;
  localparam int GAW = $clog2(GD);
  localparam int WW  = qti_pkg::WORD_W;

  // input fields
  logic [2:0]    f_e, f_th, f_al;
  logic [3:0]    f_12, f_23;
  logic [WW-1:0] f_v12, f_v23, f_vth, f_val;
  logic          in_acc;

  assign f_e   = in_tdata[2:0];
  assign f_12  = in_tdata[6:3];
  assign f_23  = in_tdata[10:7];
  assign f_th  = in_tdata[13:11];
  assign f_al  = in_tdata[16:14];
  assign f_v12 = in_tdata[48:17];
  assign f_v23 = in_tdata[80:49];
  assign f_vth = in_tdata[112:81];
  assign f_val = in_tdata[144:113];
  assign in_acc = in_tvalid && in_tready;

  function automatic logic [TAW-1:0] tab_addr(input logic [2:0] e, input logic [3:0] b12,
                                              input logic [3:0] b23, input logic [2:0] th,
                                              input logic [2:0] al);
    tab_addr = TAW'((((TAW'(e) * TAW'(S) + TAW'(b23)) * TAW'(F) + TAW'(b12)) * TAW'(P)
               + TAW'(th)) * TAW'(A) + TAW'(al));
  endfunction

  function automatic logic tab_ok(input logic [2:0] e, input logic [3:0] b12,
                                  input logic [3:0] b23, input logic [2:0] th,
                                  input logic [2:0] al);
    tab_ok = (e < E) && (b12 < F) && (b23 < S) && (th < P) && (al < A);
  endfunction

  function automatic logic [WW-1:0] absdiff(input logic [WW-1:0] a, input logic [WW-1:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  // registers
  qti_pkg::state_t state_r, state_nxt;
  logic [16:0]     held_r;
  logic [3:0]      h12_r, h23_r;
  logic [2:0]      hth_r, hal_r;
  logic [WW-1:0]   x_r [4];
  logic [WW-1:0]   grid_r [8];
  logic [3:0]      gcnt_r;
  logic            gok_r;
  logic [WW-1:0]   sp_r [4];
  logic [WW-1:0]   dlo_r [4];
  logic [WW-1:0]   dhi_r [4];
  logic [qti_pkg::TERM_WORDS-1:0][WW-1:0] term_r;
  logic [1:0]      mi_r;
  logic [2:0]      wi_r;
  logic [WW-1:0]   carry_r;
  logic [qti_pkg::DVS_W-1:0] dvs_r;
  logic [qti_pkg::ACC_W-1:0] acc_r;
  logic [3:0]      c_r;
  logic [TAW-1:0]  taddr_r;
  logic            tok_r;
  logic [WW-1:0]   res_val_r;
  logic            res_flag_r;
  logic            out_valid_r;
  logic [WW-1:0]   out_val_r;
  logic            out_flag_r;

  // held lower bins
  logic [2:0] le, lth, lal;
  logic [3:0] l12, l23;
  assign le  = held_r[16:14];
  assign l12 = held_r[13:10];
  assign l23 = held_r[9:6];
  assign lth = held_r[5:3];
  assign lal = held_r[2:0];

  // memory ports
  logic            t_we, t_re, g_we, g_re;
  logic [TAW-1:0]  t_waddr;
  logic [GAW-1:0]  g_waddr, g_raddr;
  logic [WW-1:0]   t_rdata, g_rdata;
  logic            g_rok;
  logic            div_start, div_done;
  logic [WW-1:0]   div_q;
  logic            out_free;
  logic            degen;

  assign out_free = !out_valid_r || out_tready;
  assign degen = (sp_r[0] == '0) || (sp_r[1] == '0) || (sp_r[2] == '0) || (sp_r[3] == '0);

  qti_ram #(.W(WW), .D(TSZ)) u_tab (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(f_v12),
    .re(t_re), .raddr(taddr_r), .rdata(t_rdata)
  );

  qti_ram #(.W(WW), .D(GD)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(f_v12),
    .re(g_re), .raddr(g_raddr), .rdata(g_rdata)
  );

  qti_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(acc_r), .divisor(dvs_r),
    .done(div_done), .quotient(div_q)
  );

  // load address decode
  always_comb begin
    t_we    = 1'b0;
    g_we    = 1'b0;
    t_waddr = tab_addr(f_e, f_12, f_23, f_th, f_al);
    g_waddr = '0;
    if (in_acc) begin
      case (qti_pkg::req_t'(in_tuser))
        qti_pkg::REQ_LOAD_VAL: t_we = tab_ok(f_e, f_12, f_23, f_th, f_al);
        qti_pkg::REQ_LOAD_S12: begin
          g_we    = (f_12 < F) && (f_e < E);
          g_waddr = GAW'(GAW'(f_12) * GAW'(E) + GAW'(f_e));
        end
        qti_pkg::REQ_LOAD_S23: begin
          g_we    = (f_23 < S) && (f_e < E);
          g_waddr = GAW'(GAW'(F * E) + GAW'(f_23) * GAW'(E) + GAW'(f_e));
        end
        qti_pkg::REQ_LOAD_THETA: begin
          g_we    = f_th < P;
          g_waddr = GAW'(GAW'((F + S) * E) + GAW'(f_th));
        end
        qti_pkg::REQ_LOAD_ALPHA: begin
          g_we    = f_al < A;
          g_waddr = GAW'(GAW'((F + S) * E + P) + GAW'(f_al));
        end
        default: ;
      endcase
    end
  end

  // grid read address for slot gcnt: lower then upper point per axis
  logic [3:0] gbin;
  always_comb begin
    g_raddr = '0;
    g_rok   = 1'b0;
    gbin    = '0;
    case (gcnt_r[2:1])
      2'd0: begin
        gbin    = gcnt_r[0] ? h12_r : l12;
        g_rok   = (gbin < F) && (le < E);
        g_raddr = GAW'(GAW'(gbin) * GAW'(E) + GAW'(le));
      end
      2'd1: begin
        gbin    = gcnt_r[0] ? h23_r : l23;
        g_rok   = (gbin < S) && (le < E);
        g_raddr = GAW'(GAW'(F * E) + GAW'(gbin) * GAW'(E) + GAW'(le));
      end
      2'd2: begin
        gbin    = {1'b0, gcnt_r[0] ? hth_r : lth};
        g_rok   = gbin < P;
        g_raddr = GAW'(GAW'((F + S) * E) + GAW'(gbin));
      end
      default: begin
        gbin    = {1'b0, gcnt_r[0] ? hal_r : lal};
        g_rok   = gbin < A;
        g_raddr = GAW'(GAW'((F + S) * E + P) + GAW'(gbin));
      end
    endcase
  end

  // word-serial multiply step
  logic [WW-1:0]   mul_m;
  logic [2*WW-1:0] prod;
  logic            mul_lastw;
  always_comb begin
    if (state_r == qti_pkg::ST_DMUL) begin
      mul_m = sp_r[2'(mi_r + 2'd1)];
    end else begin
      mul_m = c_r[mi_r] ? dlo_r[mi_r] : dhi_r[mi_r];
    end
    prod = (2*WW)'(term_r[wi_r]) * (2*WW)'(mul_m) + (2*WW)'(carry_r);
    mul_lastw = wi_r == {1'b0, mi_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qti_pkg::ST_IDLE:
        if (in_acc && qti_pkg::req_t'(in_tuser) == qti_pkg::REQ_QUERY) begin
          state_nxt = qti_pkg::ST_GRD;
        end
      qti_pkg::ST_GRD:  if (gcnt_r == 4'd8) state_nxt = qti_pkg::ST_SPC;
      qti_pkg::ST_SPC:  state_nxt = qti_pkg::ST_CHK;
      qti_pkg::ST_CHK:  state_nxt = degen ? qti_pkg::ST_FIN : qti_pkg::ST_DMUL;
      qti_pkg::ST_DMUL: if (mul_lastw && mi_r == 2'd2) state_nxt = qti_pkg::ST_DSTO;
      qti_pkg::ST_DSTO: state_nxt = qti_pkg::ST_CADR;
      qti_pkg::ST_CADR: state_nxt = qti_pkg::ST_CRD;
      qti_pkg::ST_CRD:  state_nxt = qti_pkg::ST_CCAP;
      qti_pkg::ST_CCAP: state_nxt = qti_pkg::ST_CMUL;
      qti_pkg::ST_CMUL: if (mul_lastw && mi_r == 2'd3) state_nxt = qti_pkg::ST_CADD;
      qti_pkg::ST_CADD: state_nxt = (c_r == 4'd15) ? qti_pkg::ST_DIVS : qti_pkg::ST_CADR;
      qti_pkg::ST_DIVS: state_nxt = qti_pkg::ST_DIVW;
      qti_pkg::ST_DIVW: if (div_done) state_nxt = qti_pkg::ST_FIN;
      qti_pkg::ST_FIN:  if (out_free) state_nxt = qti_pkg::ST_IDLE;
      default:          state_nxt = qti_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    g_re      = 1'b0;
    t_re      = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      qti_pkg::ST_IDLE: in_tready = 1'b1;
      qti_pkg::ST_GRD:  g_re = !gcnt_r[3];
      qti_pkg::ST_CRD:  t_re = 1'b1;
      qti_pkg::ST_DIVS: div_start = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qti_pkg::ST_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && qti_pkg::req_t'(in_tuser) == qti_pkg::REQ_BRACKET) begin
        held_r <= {f_e, f_12, f_23, f_th, f_al};
      end
      if (state_r == qti_pkg::ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      qti_pkg::ST_IDLE: begin
        if (in_acc) begin
          h12_r  <= f_12;
          h23_r  <= f_23;
          hth_r  <= f_th;
          hal_r  <= f_al;
          x_r[0] <= f_v12;
          x_r[1] <= f_v23;
          x_r[2] <= f_vth;
          x_r[3] <= f_val;
        end
        gcnt_r <= '0;
      end
      qti_pkg::ST_GRD: begin
        gok_r <= g_rok;
        if (gcnt_r != 4'd0) begin
          grid_r[3'(gcnt_r - 4'd1)] <= gok_r ? g_rdata : '0;
        end
        if (gcnt_r != 4'd8) begin
          gcnt_r <= gcnt_r + 4'd1;
        end
      end
      qti_pkg::ST_SPC: begin
        for (int k = 0; k < 4; k++) begin
          sp_r[k]  <= absdiff(grid_r[2*k+1], grid_r[2*k]);
          dlo_r[k] <= absdiff(grid_r[2*k], x_r[k]);
          dhi_r[k] <= absdiff(grid_r[2*k+1], x_r[k]);
        end
      end
      qti_pkg::ST_CHK: begin
        res_val_r  <= '0;
        res_flag_r <= degen;
        term_r     <= {{(qti_pkg::TERM_WORDS-1)*WW{1'b0}}, sp_r[0]};
        mi_r       <= '0;
        wi_r       <= '0;
        carry_r    <= '0;
      end
      qti_pkg::ST_DMUL, qti_pkg::ST_CMUL: begin
        term_r[wi_r] <= prod[WW-1:0];
        if (mul_lastw) begin
          term_r[3'(wi_r + 3'd1)] <= prod[2*WW-1:WW];
          carry_r <= '0;
          wi_r    <= '0;
          mi_r    <= mi_r + 2'd1;
        end else begin
          carry_r <= prod[2*WW-1:WW];
          wi_r    <= wi_r + 3'd1;
        end
      end
      qti_pkg::ST_DSTO: begin
        dvs_r <= term_r[3:0];
        acc_r <= '0;
        c_r   <= '0;
      end
      qti_pkg::ST_CADR: begin
        taddr_r <= tab_addr(le, c_r[0] ? h12_r : l12, c_r[1] ? h23_r : l23,
                            c_r[2] ? hth_r : lth, c_r[3] ? hal_r : lal);
        tok_r   <= tab_ok(le, c_r[0] ? h12_r : l12, c_r[1] ? h23_r : l23,
                          c_r[2] ? hth_r : lth, c_r[3] ? hal_r : lal);
      end
      qti_pkg::ST_CCAP: begin
        term_r  <= {{(qti_pkg::TERM_WORDS-1)*WW{1'b0}}, tok_r ? t_rdata : {WW{1'b0}}};
        mi_r    <= '0;
        wi_r    <= '0;
        carry_r <= '0;
      end
      qti_pkg::ST_CADD: begin
        acc_r <= acc_r + qti_pkg::ACC_W'(term_r);
        c_r   <= c_r + 4'd1;
      end
      qti_pkg::ST_DIVW: begin
        if (div_done) begin
          res_val_r  <= div_q;
          res_flag_r <= 1'b0;
        end
      end
      qti_pkg::ST_FIN: begin
        if (out_free) begin
          out_val_r  <= res_val_r;
          out_flag_r <= res_flag_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_val_r;
  assign out_tuser[0] = out_flag_r;

endmodule

/* tb/tb_quadrilinear_table_interpolator_top.sv */
// Self-checking testbench for quadrilinear_table_interpolator_top.
// Loads value tables and axis grids, brackets and queries them, and checks
// each result against a predictor with exact wide arithmetic. Needs qti_pkg.
`timescale 1ns / 1ps

module tb_quadrilinear_table_interpolator_top;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_ITEMS = 1000;
  localparam int QUIET_TAIL = 150;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  e;
    logic [3:0]  b12;
    logic [3:0]  b23;
    logic [2:0]  bth;
    logic [2:0]  bal;
    logic [31:0] x12;
    logic [31:0] x23;
    logic [31:0] xth;
    logic [31:0] xal;
  } interp_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        degenerate;
  } interp_res_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [151:0] in_tdata;   // energy_bin, s12_bin, s23_bin, theta_bin, alpha_bin, coords, pad
  logic [2:0]   in_tuser;   // req_type
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;  // interpolated_value
  logic [0:0]   out_tuser;  // degenerate_flag

  quadrilinear_table_interpolator_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // mirror of the block's storage
  logic [31:0] value_mirror [int];
  logic [31:0] s12_grid_mirror [128];
  logic [31:0] s23_grid_mirror [128];
  logic [31:0] theta_grid_mirror [8];
  logic [31:0] alpha_grid_mirror [8];
  logic [16:0] lower_bins_mirror;

  interp_req_t pending_reqs[$];
  interp_res_t expected_results[$];
  int          err_count;
  int          cycle_count;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] absdiff32(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int value_key(logic [2:0] e, logic [3:0] b12, logic [3:0] b23,
                                   logic [2:0] bth, logic [2:0] bal);
    return int'({e, b23, b12, bth, bal});
  endfunction

  // apply one accepted request to the mirror; queue a result for a query
  function automatic void interpolate_request(interp_req_t r);
    logic [2:0]   le, lth, lal;
    logic [3:0]   l12, l23;
    logic [31:0]  lo [4];
    logic [31:0]  hi [4];
    logic [31:0]  sp [4];
    logic [31:0]  xs [4];
    logic [191:0] acc, term, dvs, quo;
    logic [2:0]   cth, cal;
    logic [3:0]   c12, c23;
    logic [31:0]  opp;
    interp_res_t  res;
    int           key;
    case (r.kind)
      qti_pkg::REQ_LOAD_VAL:
        value_mirror[value_key(r.e, r.b12, r.b23, r.bth, r.bal)] = r.x12;
      qti_pkg::REQ_LOAD_S12:   s12_grid_mirror[{r.b12, r.e}] = r.x12;
      qti_pkg::REQ_LOAD_S23:   s23_grid_mirror[{r.b23, r.e}] = r.x12;
      qti_pkg::REQ_LOAD_THETA: theta_grid_mirror[r.bth] = r.x12;
      qti_pkg::REQ_LOAD_ALPHA: alpha_grid_mirror[r.bal] = r.x12;
      qti_pkg::REQ_BRACKET:    lower_bins_mirror = {r.e, r.b12, r.b23, r.bth, r.bal};
      qti_pkg::REQ_QUERY: begin
        {le, l12, l23, lth, lal} = lower_bins_mirror;
        lo[0] = s12_grid_mirror[{l12, le}];   hi[0] = s12_grid_mirror[{r.b12, le}];
        lo[1] = s23_grid_mirror[{l23, le}];   hi[1] = s23_grid_mirror[{r.b23, le}];
        lo[2] = theta_grid_mirror[lth];       hi[2] = theta_grid_mirror[r.bth];
        lo[3] = alpha_grid_mirror[lal];       hi[3] = alpha_grid_mirror[r.bal];
        xs[0] = r.x12; xs[1] = r.x23; xs[2] = r.xth; xs[3] = r.xal;
        for (int k = 0; k < 4; k++) sp[k] = absdiff32(hi[k], lo[k]);
        if (sp[0] == 0 || sp[1] == 0 || sp[2] == 0 || sp[3] == 0) begin
          res.value = '0;
          res.degenerate = 1'b1;
        end else begin
          acc = '0;
          for (int c = 0; c < 16; c++) begin
            c12 = c[0] ? r.b12 : l12;
            c23 = c[1] ? r.b23 : l23;
            cth = c[2] ? r.bth : lth;
            cal = c[3] ? r.bal : lal;
            key = value_key(le, c12, c23, cth, cal);
            term = value_mirror.exists(key) ? 192'(value_mirror[key]) : '0;
            for (int k = 0; k < 4; k++) begin
              opp = c[k] ? lo[k] : hi[k];
              term = term * 192'(absdiff32(opp, xs[k]));
            end
            acc = acc + term;
          end
          dvs = 192'(sp[0]) * 192'(sp[1]) * 192'(sp[2]) * 192'(sp[3]);
          if (acc >= (dvs << 32)) begin
            res.value = '1;
          end else begin
            quo = acc / dvs;
            res.value = quo[31:0];
          end
          res.degenerate = 1'b0;
        end
        expected_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic void add_req(logic [2:0] kind, logic [2:0] e, logic [3:0] b12,
                                  logic [3:0] b23, logic [2:0] bth, logic [2:0] bal,
                                  logic [31:0] x12, logic [31:0] x23,
                                  logic [31:0] xth, logic [31:0] xal);
    interp_req_t r;
    r = '{kind, e, b12, b23, bth, bal, x12, x23, xth, xal};
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [31:0] rand_between(logic [31:0] a, logic [31:0] b);
    logic [31:0] mn, span;
    mn = (a < b) ? a : b;
    span = absdiff32(a, b);
    return mn + $urandom_range(0, span);
  endfunction

  // grids, 16 corners, bracket, then one query (three in mode 1; mode 0 may add repeats).
  // mode 0: random; 1: extremes; 2: lower equals upper bin on one axis (zero spacing)
  function automatic void add_query_set(int mode);
    logic [2:0]  e, lth, lal, uth, ual;
    logic [3:0]  l12, l23, u12, u23;
    logic [31:0] glo [4];
    logic [31:0] ghi [4];
    logic [31:0] v;
    bit          wide;
    int          sel;
    e = 3'($urandom);
    l12 = 4'($urandom); l23 = 4'($urandom); lth = 3'($urandom); lal = 3'($urandom);
    u12 = 4'($urandom); u23 = 4'($urandom); uth = 3'($urandom); ual = 3'($urandom);
    if (mode == 2 || $urandom_range(0, 9) == 0) begin
      sel = $urandom_range(0, 3);
      if (sel == 0) u12 = l12;
      if (sel == 1) u23 = l23;
      if (sel == 2) uth = lth;
      if (sel == 3) ual = lal;
    end
    for (int k = 0; k < 4; k++) begin
      glo[k] = (mode == 1) ? 32'h0 : $urandom;
      ghi[k] = (mode == 1) ? 32'hFFFF_FFFF : $urandom;
      if ($urandom_range(0, 15) == 0) ghi[k] = glo[k];
    end
    if (u12 == l12) ghi[0] = glo[0];
    if (u23 == l23) ghi[1] = glo[1];
    if (uth == lth) ghi[2] = glo[2];
    if (ual == lal) ghi[3] = glo[3];
    add_req(qti_pkg::REQ_LOAD_S12, e, l12, 4'($urandom), 3'($urandom), 3'($urandom),
            glo[0], $urandom, $urandom, $urandom);
    add_req(qti_pkg::REQ_LOAD_S12, e, u12, 4'($urandom), 3'($urandom), 3'($urandom),
            ghi[0], $urandom, $urandom, $urandom);
    add_req(qti_pkg::REQ_LOAD_S23, e, 4'($urandom), l23, 3'($urandom), 3'($urandom),
            glo[1], $urandom, $urandom, $urandom);
    add_req(qti_pkg::REQ_LOAD_S23, e, 4'($urandom), u23, 3'($urandom), 3'($urandom),
            ghi[1], $urandom, $urandom, $urandom);
    add_req(qti_pkg::REQ_LOAD_THETA, 3'($urandom), 4'($urandom), 4'($urandom), lth,
            3'($urandom), glo[2], $urandom, $urandom, $urandom);
    add_req(qti_pkg::REQ_LOAD_THETA, 3'($urandom), 4'($urandom), 4'($urandom), uth,
            3'($urandom), ghi[2], $urandom, $urandom, $urandom);
    add_req(qti_pkg::REQ_LOAD_ALPHA, 3'($urandom), 4'($urandom), 4'($urandom),
            3'($urandom), lal, glo[3], $urandom, $urandom, $urandom);
    add_req(qti_pkg::REQ_LOAD_ALPHA, 3'($urandom), 4'($urandom), 4'($urandom),
            3'($urandom), ual, ghi[3], $urandom, $urandom, $urandom);
    // every corner of the cell gets a value
    for (int c = 0; c < 16; c++) begin
      sel = $urandom_range(0, 7);
      v = (mode == 1 || sel == 0) ? 32'hFFFF_FFFF : (sel == 1) ? 32'h0 : $urandom;
      add_req(qti_pkg::REQ_LOAD_VAL, e, c[0] ? u12 : l12, c[1] ? u23 : l23,
              c[2] ? uth : lth, c[3] ? ual : lal, v, $urandom, $urandom, $urandom);
    end
    add_req(qti_pkg::REQ_BRACKET, e, l12, l23, lth, lal, $urandom, $urandom, $urandom,
            $urandom);
    // queries on the same cell; coordinates mostly inside it
    do begin
      wide = (mode == 0) && ($urandom_range(0, 4) == 0);
      if (mode == 1) begin
        add_req(qti_pkg::REQ_QUERY, 3'($urandom), u12, u23, uth, ual,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_req(qti_pkg::REQ_QUERY, 3'($urandom), u12, u23, uth, ual, '1, '1, '1, '1);
        add_req(qti_pkg::REQ_QUERY, 3'($urandom), l12, l23, lth, lal, '1, '1, '1, '1);
      end else begin
        add_req(qti_pkg::REQ_QUERY, 3'($urandom), u12, u23, uth, ual,
                wide ? $urandom : rand_between(glo[0], ghi[0]),
                wide ? $urandom : rand_between(glo[1], ghi[1]),
                wide ? $urandom : rand_between(glo[2], ghi[2]),
                wide ? $urandom : rand_between(glo[3], ghi[3]));
      end
    end while (mode == 0 && $urandom_range(0, 2) == 0);
  endfunction

  // request driver: drive at the falling edge, track acceptance at the rising edge
  int in_idle;
  bit in_taken;
  interp_req_t in_cur;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_taken = in_tvalid && in_tready && rst_n;
    if (in_taken) interpolate_request(in_cur);
  end

  always @(negedge clk) begin
    if (rst_n && (in_taken || !in_tvalid)) begin
      if (in_idle > 0) begin
        in_idle <= in_idle - 1;
        in_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_idle <= $urandom_range(0, 10);
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_cur = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= in_cur.kind;
        in_tdata <= {7'd0, in_cur.xal, in_cur.xth, in_cur.x23, in_cur.x12,
                     in_cur.bal, in_cur.bth, in_cur.b23, in_cur.b12, in_cur.e};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and backpressure
  int out_stall;
  interp_res_t got;
  interp_res_t want;

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata, out_tuser[0]};
      if (expected_results.size() == 0) begin
        $error("unexpected result: interpolated_value %h degenerate_flag %b",
               got.value, got.degenerate);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.value !== want.value) begin
          $error("interpolated_value: expected %h actual %h", want.value, got.value);
          err_count++;
        end
        if (got.degenerate !== want.degenerate) begin
          $error("degenerate_flag: expected %b actual %b", want.degenerate, got.degenerate);
          err_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    in_idle = 0;
    in_taken = 1'b0;
    out_stall = 0;
    err_count = 0;
    cycle_count = 0;
    quiet = 1'b0;
    lower_bins_mirror = '0;

    // directed: extreme grids and values, zero spacing, unused kind
    add_query_set(1);
    add_query_set(2);
    add_req(REQ_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1, '1);

    // random: mostly full cells, with stray loads and unused kinds between them
    while (pending_reqs.size() < TARGET_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        add_req(($urandom_range(0, 1) == 0) ? REQ_UNUSED : qti_pkg::REQ_LOAD_VAL,
                3'($urandom), 4'($urandom), 4'($urandom), 3'($urandom), 3'($urandom),
                $urandom, $urandom, $urandom, $urandom);
      else
        add_query_set(0);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() < QUIET_TAIL);
    quiet = 1'b1;
    // check at clock edges so a request just popped is seen as in flight
    while (!(pending_reqs.size() == 0 && !in_tvalid && expected_results.size() == 0))
      @(posedge clk);
    repeat (400) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
hdl/qti_pkg.sv
hdl/qti_ram.sv
hdl/qti_div.sv
hdl/quadrilinear_table_interpolator_top.sv
tb/tb_quadrilinear_table_interpolator_top.sv
